/* rtl/core/sapq_pkg.sv */
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared types and codes for the sorted array priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sapq_pkg;

    localparam int VAL_W = 32;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_DUMP   = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_DELETED   = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_ENTRY     = 3'd5;

    typedef logic signed [VAL_W-1:0] t_val;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_DELETE,
        OP_ROTATE
    } t_op;

    typedef struct packed {
        t_op  op;
        t_val value;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        t_val       value;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        t_val       value_out;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/sapq_cell.sv */
// ----------------------------------------------------------------------------
// sapq_cell
// One slot of the sorted row: holds an entry and trades it with neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module sapq_cell (
    input  wire             i_clk,
    input  sapq_pkg::t_cmd  i_cmd,
    input  wire             i_found,
    input  wire             i_valid,
    input  sapq_pkg::t_val  i_left_val,
    input  wire             i_left_take,
    input  sapq_pkg::t_val  i_right_val,
    input  wire             i_right_valid,
    input  sapq_pkg::t_val  i_head_val,
    output sapq_pkg::t_val  o_val,
    output logic            o_take,
    output logic            o_match
);
    import sapq_pkg::*;

    t_val r_val;
    t_val n_val;

    // insert lands here or shifts toward tail when the new value belongs at or above
    assign o_take  = !i_valid || (i_cmd.value >= r_val);
    assign o_match = i_valid && (i_cmd.value == r_val);
    assign o_val   = r_val;

    always_comb begin
        n_val = r_val;
        unique case (i_cmd.op)
            OP_INSERT: begin
                if (o_take) begin
                    n_val = i_left_take ? i_left_val : i_cmd.value;
                end
            end
            OP_DELETE: begin
                if (i_found && (!i_valid || r_val <= i_cmd.value)) begin
                    n_val = i_right_val;
                end
            end
            OP_ROTATE: begin
                if (i_valid) begin
                    n_val = i_right_valid ? i_right_val : i_head_val;
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

`default_nettype wire

/* rtl/core/sorted_array_priority_queue_top.sv */
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_top
// Descending sorted queue built from a row of entry cells.
// ----------------------------------------------------------------------------
// Insert and delete: result in the cycle after accept, one item per cycle
// while no dump is busy. Dump: count results, one per cycle, the first one
// after r_dump is set; busy while the cell row rotates one entry to the
// head per cycle. An empty dump answers like an insert, with one result.
// Reset clears the count and control only; entries need no clearing.
`default_nettype none

module sorted_array_priority_queue_top #(
    parameter int DEPTH = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    input  sapq_pkg::t_req      i_req,
    output logic                busy,
    output logic                o_strobe,
    output sapq_pkg::t_result   o_result
);
    import sapq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE      = CW'(1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_remain;
    logic          r_dump;
    logic          r_strobe;
    t_result       r_result;

    t_cmd          cmd;
    logic          accept;
    logic          found;
    logic [DEPTH-1:0] valid;
    logic [DEPTH-1:0] take;
    logic [DEPTH-1:0] match;
    t_val          vals [DEPTH];

    assign accept = start && !r_dump;
    assign busy   = r_dump;
    assign found  = |match;

    always_comb begin
        cmd.value = i_req.value;
        cmd.op    = OP_NONE;
        if (r_dump) begin
            cmd.op = OP_ROTATE;
        end else if (accept) begin
            if (i_req.req_type == REQ_INSERT && r_count != FULL_CNT) begin
                cmd.op = OP_INSERT;
            end else if (i_req.req_type == REQ_DELETE && r_count != '0) begin
                cmd.op = OP_DELETE;
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(g);
        t_val left_val;
        logic left_take;
        t_val right_val;
        logic right_valid;

        assign valid[g] = IDX < r_count;

        if (g == 0) begin : g_head
            assign left_val  = '0;
            assign left_take = 1'b0;
        end else begin : g_mid
            assign left_val  = vals[g-1];
            assign left_take = take[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_val   = '0;
            assign right_valid = 1'b0;
        end else begin : g_body
            assign right_val   = vals[g+1];
            assign right_valid = valid[g+1];
        end

        sapq_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (cmd),
            .i_found       (found),
            .i_valid       (valid[g]),
            .i_left_val    (left_val),
            .i_left_take   (left_take),
            .i_right_val   (right_val),
            .i_right_valid (right_valid),
            .i_head_val    (vals[0]),
            .o_val         (vals[g]),
            .o_take        (take[g]),
            .o_match       (match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_remain <= '0;
            r_dump   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            if (r_dump) begin
                r_strobe           <= 1'b1;
                r_result.status    <= ST_ENTRY;
                r_result.value_out <= vals[0];
                r_result.last      <= (r_remain == ONE);
                r_remain           <= r_remain - ONE;
                if (r_remain == ONE) begin
                    r_dump <= 1'b0;
                end
            end else if (accept) begin
                r_result.last <= 1'b1;
                unique case (i_req.req_type)
                    REQ_INSERT: begin
                        r_strobe           <= 1'b1;
                        r_result.value_out <= i_req.value;
                        if (r_count == FULL_CNT) begin
                            r_result.status <= ST_FULL;
                        end else begin
                            r_result.status <= ST_INSERTED;
                            r_count         <= r_count + ONE;
                        end
                    end
                    REQ_DELETE: begin
                        r_strobe           <= 1'b1;
                        r_result.value_out <= i_req.value;
                        if (r_count == '0) begin
                            r_result.status <= ST_EMPTY;
                        end else if (found) begin
                            r_result.status <= ST_DELETED;
                            r_count         <= r_count - ONE;
                        end else begin
                            r_result.status <= ST_NOT_FOUND;
                        end
                    end
                    REQ_DUMP: begin
                        if (r_count == '0) begin
                            r_strobe           <= 1'b1;
                            r_result.status    <= ST_EMPTY;
                            r_result.value_out <= '0;
                        end else begin
                            r_strobe <= 1'b0;
                            r_dump   <= 1'b1;
                            r_remain <= r_count;
                        end
                    end
                    default: begin
                        r_strobe <= 1'b0;
                    end
                endcase
            end else begin
                r_strobe <= 1'b0;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req.req_type == REQ_INSERT || i_req.req_type == REQ_DELETE)
        |=> o_strobe && o_result.last)
        else $error("insert or delete gave no final result");

    a_dump_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_strobe && o_result.status == ST_ENTRY)
        else $error("dump cycle gave no entry");

    a_dump_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy && r_remain == ONE |=> !busy && o_result.last)
        else $error("dump did not end on last entry");

endmodule

`default_nettype wire

/* bench/sapq_checker.sv */
// ----------------------------------------------------------------------------
// sapq_checker
// Watches the request and result channels of the sorted array priority
// queue, keeps its own sorted copy of the stored values, and compares every
// result strobe field by field with the oldest result still due.
// ----------------------------------------------------------------------------
`default_nettype none

module sapq_checker #(
    parameter int DEPTH = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire                 i_busy,
    input  sapq_pkg::t_req      i_req,
    input  wire                 i_strobe,
    input  sapq_pkg::t_result   i_result,
    output int                  o_fail_count,
    output int                  o_pending
);

    import sapq_pkg::*;

    t_val    ordered [DEPTH];
    int      fill;
    t_result due_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fill         = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    function automatic t_result make_result(logic [2:0] st, t_val v, logic tail);
        t_result r;
        r.status    = st;
        r.value_out = v;
        r.last      = tail;
        return r;
    endfunction

    // Updates the sorted copy and queues the results one request causes.
    function automatic void apply_request(t_req r);
        int   pos;
        t_val v;
        v = r.value;
        case (r.req_type)
            REQ_INSERT: begin
                if (fill >= DEPTH) begin
                    due_results.push_back(make_result(ST_FULL, v, 1'b1));
                end else begin
                    pos = fill;
                    for (int i = 0; i < fill; i++) begin
                        if (v >= ordered[i]) begin
                            pos = i;
                            break;
                        end
                    end
                    for (int i = fill; i > pos; i--) ordered[i] = ordered[i-1];
                    ordered[pos] = v;
                    fill++;
                    due_results.push_back(make_result(ST_INSERTED, v, 1'b1));
                end
            end
            REQ_DELETE: begin
                if (fill == 0) begin
                    due_results.push_back(make_result(ST_EMPTY, v, 1'b1));
                end else begin
                    pos = fill;
                    for (int i = 0; i < fill; i++) begin
                        if (ordered[i] == v) begin
                            pos = i;
                            break;
                        end
                    end
                    if (pos >= fill) begin
                        due_results.push_back(make_result(ST_NOT_FOUND, v, 1'b1));
                    end else begin
                        for (int i = pos; i + 1 < fill; i++) ordered[i] = ordered[i+1];
                        fill--;
                        due_results.push_back(make_result(ST_DELETED, v, 1'b1));
                    end
                end
            end
            REQ_DUMP: begin
                if (fill == 0) begin
                    due_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
                end else begin
                    for (int i = 0; i < fill; i++) begin
                        due_results.push_back(make_result(ST_ENTRY, ordered[i],
                                                          i + 1 == fill));
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic check_result(input t_result got);
        t_result want;
        if (due_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result status %0d value %0d last %0d",
                                      got.status, got.value_out, got.last));
        end else begin
            want = due_results.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          got.status, want.status));
            if (got.value_out !== want.value_out)
                report_mismatch($sformatf("value_out %0d, expected %0d",
                                          got.value_out, want.value_out));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0d, expected %0d",
                                          got.last, want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill = 0;
            due_results.delete();
        end else begin
            if (i_strobe !== 1'b0) check_result(i_result);
            if (i_start === 1'b1 && i_busy === 1'b0) apply_request(i_req);
        end
        o_pending = due_results.size();
    end

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random insert, delete and dump requests into the sorted
// array priority queue in bursts with random gaps; the checker beside the
// block predicts and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import sapq_pkg::*;

    localparam int         DEPTH       = 16;
    localparam int         ITEM_TARGET = 470;
    localparam int         CYCLE_LIMIT = 200000;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam t_val       VAL_MIN     = 32'sh80000000;
    localparam t_val       VAL_MAX     = 32'sh7fffffff;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_req    i_req;
    logic    busy;
    logic    o_strobe;
    t_result o_result;
    int      fail_count;
    int      pending;
    int      cycles;
    int      sent;
    int      burst_left;
    t_val    recent [8];

    sorted_array_priority_queue_top #(.DEPTH(DEPTH)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    sapq_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic idle_gap(input int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Holds one item on the port until the block takes it.
    task automatic issue(input logic [1:0] kind, input t_val v);
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= '{req_type: kind, value: v};
        do @(posedge i_clk); while (busy !== 1'b0);
        if (kind != REQ_UNUSED) sent++;
        if (kind == REQ_INSERT) recent[$urandom_range(0, 7)] = v;
        burst_left--;
        if (burst_left <= 0) begin
            idle_gap($urandom_range(1, 6));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic t_val pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return t_val'(int'($urandom_range(0, 8)) - 4);
            5:             return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
            default:       return t_val'($urandom());
        endcase
    endfunction

    function automatic t_val pick_victim();
        if ($urandom_range(0, 9) < 6) return recent[$urandom_range(0, 7)];
        return pick_value();
    endfunction

    task automatic random_item(input int phase);
        int roll;
        roll = $urandom_range(0, 99);
        case (phase)
            0: begin
                if (roll < 90) issue(REQ_INSERT, pick_value());
                else           issue(REQ_DUMP, pick_value());
            end
            1: begin
                if (roll < 85)      issue(REQ_DELETE, pick_victim());
                else if (roll < 95) issue(REQ_DUMP, pick_value());
                else                issue(REQ_UNUSED, pick_value());
            end
            2: begin
                if (roll < 45)      issue(REQ_INSERT, pick_value());
                else if (roll < 80) issue(REQ_DELETE, pick_victim());
                else if (roll < 96) issue(REQ_DUMP, pick_value());
                else                issue(REQ_UNUSED, pick_value());
            end
            default: begin
                if (roll < 40)      issue(REQ_DUMP, pick_value());
                else if (roll < 80) issue(REQ_INSERT, pick_value());
                else                issue(REQ_DELETE, pick_victim());
            end
        endcase
    endtask

    initial begin
        int phase;
        int len;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req      = '0;
        sent       = 0;
        burst_left = 4;
        foreach (recent[k]) recent[k] = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue(REQ_DELETE, VAL_MIN);
        issue(REQ_DUMP, VAL_MAX);
        issue(REQ_UNUSED, VAL_MAX);
        issue(REQ_INSERT, VAL_MAX);
        issue(REQ_INSERT, VAL_MIN);
        issue(REQ_INSERT, '0);
        issue(REQ_INSERT, -1);
        issue(REQ_INSERT, VAL_MAX);
        issue(REQ_INSERT, 1);
        issue(REQ_INSERT, VAL_MIN);
        issue(REQ_DUMP, '0);
        issue(REQ_DELETE, 12345);
        issue(REQ_DELETE, VAL_MAX);
        issue(REQ_DELETE, VAL_MIN);
        issue(REQ_DELETE, -1);
        issue(REQ_DUMP, -1);
        issue(REQ_UNUSED, '0);
        issue(REQ_DELETE, '0);
        issue(REQ_DELETE, 1);
        issue(REQ_DELETE, VAL_MAX);
        issue(REQ_DELETE, VAL_MIN);
        issue(REQ_DUMP, VAL_MIN);
        drain_results();

        while (sent < ITEM_TARGET) begin
            phase = $urandom_range(0, 3);
            len   = (phase == 0) ? $urandom_range(18, 30) : $urandom_range(8, 30);
            repeat (len) random_item(phase);
            if ($urandom_range(0, 3) == 0) drain_results();
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/sapq_pkg.sv
rtl/core/sapq_cell.sv
rtl/core/sorted_array_priority_queue_top.sv
bench/sapq_checker.sv
bench/tb_top.sv
